@@ hdl/ebts_pkg.sv @@
`default_nettype none
package ebts_pkg;

    localparam int NumCfg = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgW = 16;

    // register indexes
    localparam logic [CfgIdxW-1:0] CfgPtMinB   = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgPtMinE   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgChi2MaxB = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgChi2MaxE = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgRelMaxB  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgRelMaxE  = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgDphiMaxB = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgDphiMaxE = 3'd7;

    localparam logic [12:0] BarrelEtaLimit = 13'd1514;
    localparam logic [15:0] EnergyFloor    = 16'd16;
    localparam logic [6:0]  WeightRel      = 7'd65;
    localparam logic [6:0]  WeightChi2     = 7'd104;
    localparam logic [23:0] ScoreMax       = 24'hFFFFFF;
    localparam int DivSteps = 28;
    localparam int InW  = 142;
    localparam int OutW = 104;

    // stored track fields (raw input bits)
    typedef struct packed {
        logic [15:0] d0;
        logic [15:0] dz;
        logic [15:0] pt;
        logic [12:0] eta;
        logic [15:0] phi;
        logic [15:0] chi2;
        logic [1:0]  charge;
    } t_track;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture word, start judging
        logic div_step;  // one quotient bit
        logic update;    // fold track into electron state
        logic sentinel;  // load sentinel result
        logic clear;     // reset electron state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic no_tracks;
        logic last;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

@@ hdl/electron_best_track_select.sv @@
`default_nettype none
// Picks the best track of one electron. Each track arrives as one word; the
// result word appears after the word flagged last (or after a no-tracks word).
// A track word not flagged last passes through these steps before the next
// word is accepted: capture, the one-bit-a-cycle relative energy divider,
// a state that sees the divider finish, and an update of the best-track state.
// A last word then also passes its result to the output register, and a
// no-tracks word skips the divider and the update and goes to that output step;
// either waits longer while an earlier result is still held. The output register
// lets the next word in while a result waits.
module electron_best_track_select (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: electron_pt, electron_eta, electron_phi, track_pt, track_phi,
    // track_chi2, track_d0, track_dz, track_eta, track_charge
    input  wire logic [143:0] s_axis_tdata,
    input  wire logic         s_axis_tlast,   // last_track
    input  wire logic         s_axis_tuser,   // no_tracks
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: best_d0, best_dz, best_pt, best_eta, best_phi, best_chi2,
    // best_charge, passed_cuts
    output logic [103:0]      m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);
    ebts_pkg::t_cmd    w_cmd;
    ebts_pkg::t_status w_status;
    logic w_out_free, w_fire;
    logic [ebts_pkg::InW-1:0] w_word;

    assign w_fire = s_axis_tvalid && s_axis_tready;
    assign w_word = {s_axis_tuser, s_axis_tlast, s_axis_tdata[139:0]};

    ebts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_out_free(w_out_free), .i_status(w_status), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready)
    );

    ebts_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(w_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_out_ready(m_axis_tready), .o_status(w_status),
        .o_out_free(w_out_free), .o_out_valid(m_axis_tvalid),
        .o_out_word(m_axis_tdata)
    );
endmodule
`default_nettype wire

@@ hdl/ebts_ctrl.sv @@
`default_nettype none
module ebts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_fire,
    input  wire logic             i_out_free,
    input  wire ebts_pkg::t_status i_status,
    output ebts_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready
);
    ebts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ebts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ebts_pkg::ST_IDLE: begin
                if (i_in_fire) n_state = ebts_pkg::ST_DIV;
            end
            ebts_pkg::ST_DIV: begin
                if (i_status.no_tracks) n_state = ebts_pkg::ST_OUT;
                else if (i_status.div_done) n_state = ebts_pkg::ST_UPDATE;
            end
            ebts_pkg::ST_UPDATE: begin
                n_state = i_status.last ? ebts_pkg::ST_OUT : ebts_pkg::ST_IDLE;
            end
            ebts_pkg::ST_OUT: begin
                if (i_out_free) n_state = ebts_pkg::ST_IDLE;
            end
            default: n_state = ebts_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ebts_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            ebts_pkg::ST_DIV: begin
                o_cmd.div_step = !i_status.no_tracks && !i_status.div_done;
            end
            ebts_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ebts_pkg::ST_OUT: begin
                // result goes to the output register once it is free
                if (i_out_free) begin
                    o_cmd.sentinel = i_status.no_tracks;
                    o_cmd.clear = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/ebts_dp.sv @@
`default_nettype none
module ebts_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ebts_pkg::t_cmd    i_cmd,
    input  wire logic [ebts_pkg::InW-1:0] i_word,
    input  wire logic              i_cfg_we,
    input  wire logic [ebts_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [ebts_pkg::CfgW-1:0]    i_cfg_data,
    input  wire logic              i_out_ready,
    output ebts_pkg::t_status      o_status,
    output logic                   o_out_free,
    output logic                   o_out_valid,
    output logic [ebts_pkg::OutW-1:0] o_out_word
);
    logic [ebts_pkg::CfgW-1:0] r_cfg [ebts_pkg::NumCfg];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ebts_pkg::NumCfg; k++) r_cfg[k] <= '0;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // unpack input word
    logic [15:0] w_ept, w_ephi;
    logic [12:0] w_eeta;
    ebts_pkg::t_track w_trk;
    always_comb begin
        w_ept = i_word[15:0];
        w_eeta = i_word[28:16];
        w_ephi = i_word[44:29];
        w_trk.pt = i_word[60:45];
        w_trk.phi = i_word[76:61];
        w_trk.chi2 = i_word[92:77];
        w_trk.d0 = i_word[108:93];
        w_trk.dz = i_word[124:109];
        w_trk.eta = i_word[137:125];
        w_trk.charge = i_word[139:138];
    end

    // stage: derived per-track values
    logic [12:0] w_aeta;
    logic        w_reg;
    logic [15:0] w_e, w_diff, w_d;
    logic [15:0] w_draw;
    always_comb begin
        w_aeta = w_eeta[12] ? 13'(-w_eeta) : w_eeta;
        w_reg = (w_eeta == 13'h1000) || (w_aeta > ebts_pkg::BarrelEtaLimit);
        w_e = (w_ept > ebts_pkg::EnergyFloor) ? w_ept : ebts_pkg::EnergyFloor;
        w_diff = (w_e > w_trk.pt) ? w_e - w_trk.pt : w_trk.pt - w_e;
        w_draw = w_trk.phi - w_ephi;
        w_d = w_draw[15] ? 16'(-w_draw) : w_draw;
    end

    ebts_pkg::t_track r_trk;
    logic        r_reg, r_last, r_nt;
    logic [15:0] r_e;
    logic [16:0] r_dmag;
    logic [27:0] r_num;      // diff*4096, shifted out msb first
    logic [16:0] r_rem;
    logic [27:0] r_quo;
    logic [4:0]  r_cnt;

    // dphi magnitude 0..32768 needs 17-bit form only at 32768
    logic [16:0] w_dmag;
    always_comb w_dmag = (w_draw == 16'h8000) ? 17'h08000 : {1'b0, w_d};

    // restoring divider, bits 16 and above of the quotient only mark saturation
    logic [16:0] w_rem_sh, w_rem_sub;
    always_comb begin
        w_rem_sh = {r_rem[15:0], r_num[27]};
        w_rem_sub = w_rem_sh - {1'b0, r_e};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_trk <= w_trk;
            r_reg <= w_reg;
            r_last <= i_word[140];
            r_nt <= i_word[141];
            r_e <= w_e;
            r_dmag <= w_dmag;
            r_num <= {w_diff, 12'd0};
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[26:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
            if (!w_rem_sub[16]) begin
                r_rem <= w_rem_sub;
                r_quo <= {r_quo[26:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[26:0], 1'b0};
            end
        end
    end

    // 28 quotient bits, produced one per cycle
    always_comb begin
        o_status.no_tracks = r_nt;
        o_status.last = r_last;
        o_status.div_done = (r_cnt == 5'(ebts_pkg::DivSteps));
    end

    // cuts and score
    logic        w_pass;
    logic [15:0] w_rel;
    logic [24:0] w_score;
    logic [23:0] w_sc;
    logic [15:0] w_ptmin, w_chimax, w_relmax, w_dmax;
    always_comb begin
        w_ptmin = r_cfg[r_reg ? ebts_pkg::CfgPtMinE : ebts_pkg::CfgPtMinB];
        w_chimax = r_cfg[r_reg ? ebts_pkg::CfgChi2MaxE : ebts_pkg::CfgChi2MaxB];
        w_relmax = r_cfg[r_reg ? ebts_pkg::CfgRelMaxE : ebts_pkg::CfgRelMaxB];
        w_dmax = r_cfg[r_reg ? ebts_pkg::CfgDphiMaxE : ebts_pkg::CfgDphiMaxB];
        // diff*4096 <= relmax*e: quotient below relmax, or equal with no remainder
        w_pass = (r_trk.pt >= w_ptmin) && (r_trk.chi2 <= w_chimax)
              && ((r_quo < {12'd0, w_relmax})
                  || ((r_quo == {12'd0, w_relmax}) && (r_rem == 17'd0)))
              && (r_dmag <= {1'b0, w_dmax});
        w_rel = (r_quo > 28'd65535) ? 16'hFFFF : r_quo[15:0];
        w_score = 25'({r_dmag, 8'd0}) + 25'(w_rel * ebts_pkg::WeightRel)
                + 25'(r_trk.chi2 * ebts_pkg::WeightChi2);
        w_sc = (w_score > {1'b0, ebts_pkg::ScoreMax}) ? ebts_pkg::ScoreMax
                                                     : w_score[23:0];
    end

    // electron state
    logic [23:0]      r_best_score;
    ebts_pkg::t_track r_best, r_first;
    logic             r_any, r_at_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_best_score <= ebts_pkg::ScoreMax;
            r_best <= '0;
            r_first <= '0;
            r_any <= 1'b0;
            r_at_first <= 1'b1;
        end else if (i_cmd.update) begin
            if (w_pass && (!r_any || w_sc < r_best_score)) begin
                r_best_score <= w_sc;
                r_best <= r_trk;
                r_any <= 1'b1;
            end
            if (r_at_first) begin
                r_first <= r_trk;
                r_at_first <= 1'b0;
            end
        end
    end

    // output register
    ebts_pkg::t_track w_sel;
    always_comb begin
        w_sel = r_any ? r_best : r_first;
    end

    logic r_ov;
    logic [ebts_pkg::OutW-1:0] r_ow;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.clear) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            if (i_cmd.sentinel) begin
                r_ow <= {4'd0, 1'b0, 2'd0, 17'h10000, 17'h10000,
                         14'd4096, 17'h1FFFF, 16'd32767, 16'd32767};
            end else begin
                r_ow <= {4'd0, r_any, w_sel.charge, {1'b0, w_sel.chi2},
                         {1'b0, w_sel.phi}, {w_sel.eta[12], w_sel.eta},
                         {1'b0, w_sel.pt}, w_sel.dz, w_sel.d0};
            end
        end
    end
    assign o_out_valid = r_ov;
    assign o_out_word = r_ow;
    assign o_out_free = !r_ov || i_out_ready;
endmodule
`default_nettype wire

@@ hdl/ebts_checker.sv @@
`default_nettype none
module ebts_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);
    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no input taken in the cycle after one is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");

    // passed_cuts never set on a sentinel result
    a_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[48:32] == 17'h1FFFF |-> !m_axis_tdata[99])
        else $error("sentinel with pass flag");

    // a no-tracks word yields a result
    a_nt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |-> ##3 m_axis_tvalid)
        else $error("no sentinel result");
endmodule

bind electron_best_track_select ebts_checker u_chk (.*);
`default_nettype wire
